### rtl/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types and constants of the separable bilinear resampler.
// ----------------------------------------------------------------------------
package sbr_pkg;

  // fixed point and field widths
  localparam int FRAC_BITS = 16;
  localparam int STEP_W    = 24;
  localparam int COORD_W   = 10;
  localparam int POS_W     = COORD_W + STEP_W;
  localparam int IDX_W     = 8;
  localparam int BANK_AW   = 2 * (IDX_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int SRC_CFG_W = 9;
  localparam int TGT_CFG_W = 11;
  localparam int CFG_DATA_W = TGT_CFG_W;

  localparam logic [SRC_CFG_W-1:0] MAX_SRC = 9'd256;
  localparam logic [TGT_CFG_W-1:0] MAX_TGT = 11'd1024;
  localparam logic [STEP_W-1:0]    FIX_ONE = STEP_W'(1) << FRAC_BITS;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } cfg_reg_t;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // per-lane stage enables
  typedef struct packed {
    logic h_en;
  } lane_ctl_t;

endpackage

### rtl/sbr_if.sv
// ----------------------------------------------------------------------------
// sbr request / response channels
// Valid-ready channels carrying pixel requests and resampled results.
// ----------------------------------------------------------------------------
interface sbr_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [9:0] pos_x;
  logic [9:0] pos_y;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, req_type, pos_x, pos_y, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, red_in, green_in, blue_in,
                  output ready);
endinterface

interface sbr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       out_of_range;

  modport source (output valid, red_out, green_out, blue_out, out_of_range,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, out_of_range,
                  output ready);
endinterface

### rtl/separable_bilinear_resampler.sv
// Path: a read passes the position, bank read, lane row and output registers.
// Throughput: one transaction per cycle, writes and reads mixed, while the
//   output is not stalled, set by four parity banks serving all four neighbours.
// After each configuration write the steps are recomputed by bit-serial
//   dividers; requests are held off until both finish. Reset is synchronous
//   and clears control state; the source image is undefined until written.
// ----------------------------------------------------------------------------
// separable_bilinear_resampler
// Source image store with a pipelined bilinear read path, three color lanes.
// ----------------------------------------------------------------------------
module separable_bilinear_resampler
  import sbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sbr_req_if.sink               req,
  sbr_rsp_if.source             rsp
);

  logic [SRC_CFG_W-1:0] source_width, source_height;
  logic [TGT_CFG_W-1:0] target_width, target_height;
  logic                 cfg_pending;
  logic                 col_busy, row_busy, step_busy;
  logic [STEP_W-1:0]    col_quo, row_quo, column_step, row_step;
  logic [SRC_CFG_W-1:0] src_v;
  logic [TGT_CFG_W-1:0] tgt_v;

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;
  logic rd_acc, wr_acc;

  logic [POS_W-1:0] px1, py1;
  logic             oor1, oor2, oor3;
  logic [17:0]      ix, iy;
  logic [18:0]      ix1, iy1;
  logic [IDX_W-1:0] sw_m1, sh_m1, x0, x1, y0, y1;
  logic [FRAC_BITS-1:0] fx2, fy2;
  logic             x0p, x1p, y0p, y1p;
  logic [PIX_W-1:0] bank_q [4];
  logic [PIX_W-1:0] p00, p01, p10, p11;
  logic [CH_W-1:0]  lane_pix [3];
  lane_ctl_t        lane_ctl;

  logic [CH_W-1:0] red_r, green_r, blue_r;
  logic            oor_r;

  // saturate incoming register values
  always_comb begin
    src_v = cfg_data[SRC_CFG_W-1:0];
    if (src_v == '0) src_v = SRC_CFG_W'(1);
    else if (src_v > MAX_SRC) src_v = MAX_SRC;
    tgt_v = cfg_data;
    if (tgt_v == '0) tgt_v = TGT_CFG_W'(1);
    else if (tgt_v > MAX_TGT) tgt_v = MAX_TGT;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_CFG_W'(1);
      source_height <= SRC_CFG_W'(1);
      target_width  <= TGT_CFG_W'(1);
      target_height <= TGT_CFG_W'(1);
      cfg_pending   <= 1'b0;
    end else begin
      cfg_pending <= cfg_we;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SOURCE_WIDTH:  source_width  <= src_v;
          REG_SOURCE_HEIGHT: source_height <= src_v;
          REG_TARGET_WIDTH:  target_width  <= tgt_v;
          REG_TARGET_HEIGHT: target_height <= tgt_v;
          default: ;
        endcase
      end
    end
  end

  // step dividers, one per axis
  sbr_step_div u_col_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_pending),
    .dividend ({8'(source_width - 9'd1), 16'd0}),
    .divisor  (10'(target_width - 11'd1)),
    .quotient (col_quo),
    .busy     (col_busy)
  );

  sbr_step_div u_row_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_pending),
    .dividend ({8'(source_height - 9'd1), 16'd0}),
    .divisor  (10'(target_height - 11'd1)),
    .quotient (row_quo),
    .busy     (row_busy)
  );

  assign step_busy   = cfg_pending | col_busy | row_busy;
  assign column_step = (target_width == TGT_CFG_W'(1)) ? FIX_ONE : col_quo;
  assign row_step    = (target_height == TGT_CFG_W'(1)) ? FIX_ONE : row_quo;

  // pipeline flow control
  assign adv4 = !v4 || rsp.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign req.ready = !step_busy && adv1;
  assign rd_acc = req.valid && req.ready && (req.req_type == REQ_READ);
  assign wr_acc = req.valid && req.ready && (req.req_type == REQ_WRITE)
                  && (req.pos_x[9:8] == 2'b00) && (req.pos_y[9:8] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= rd_acc;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // stage 1: source positions
  always_ff @(posedge clk) begin
    if (adv1) begin
      px1  <= POS_W'(req.pos_x) * POS_W'(column_step);
      py1  <= POS_W'(req.pos_y) * POS_W'(row_step);
      oor1 <= (11'(req.pos_x) >= target_width) || (11'(req.pos_y) >= target_height);
    end
  end

  // neighbour indexes with edge clamp
  always_comb begin
    ix    = px1[POS_W-1:FRAC_BITS];
    iy    = py1[POS_W-1:FRAC_BITS];
    ix1   = {1'b0, ix} + 19'd1;
    iy1   = {1'b0, iy} + 19'd1;
    sw_m1 = 8'(source_width - 9'd1);
    sh_m1 = 8'(source_height - 9'd1);
    x0    = (ix  >= 18'(source_width))  ? sw_m1 : ix[IDX_W-1:0];
    x1    = (ix1 >= 19'(source_width))  ? sw_m1 : ix1[IDX_W-1:0];
    y0    = (iy  >= 18'(source_height)) ? sh_m1 : iy[IDX_W-1:0];
    y1    = (iy1 >= 19'(source_height)) ? sh_m1 : iy1[IDX_W-1:0];
  end

  // parity banks: bank index is {row parity, column parity}
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic RP = b[1];
    localparam logic CP = b[0];
    logic [IDX_W-1:0] rrow, rcol;
    assign rrow = (y0[0] == RP) ? y0 : y1;
    assign rcol = (x0[0] == CP) ? x0 : x1;
    sbr_bank u_bank (
      .clk   (clk),
      .we    (wr_acc && (req.pos_y[0] == RP) && (req.pos_x[0] == CP)),
      .waddr ({req.pos_y[IDX_W-1:1], req.pos_x[IDX_W-1:1]}),
      .wdata ({req.blue_in, req.green_in, req.red_in}),
      .re    (adv2),
      .raddr ({rrow[IDX_W-1:1], rcol[IDX_W-1:1]}),
      .rdata (bank_q[b])
    );
  end

  // stage 2: fractions and bank selects
  always_ff @(posedge clk) begin
    if (adv2) begin
      fx2  <= px1[FRAC_BITS-1:0];
      fy2  <= py1[FRAC_BITS-1:0];
      x0p  <= x0[0];
      x1p  <= x1[0];
      y0p  <= y0[0];
      y1p  <= y1[0];
      oor2 <= oor1;
    end
  end

  always_comb begin
    p00 = bank_q[{y0p, x0p}];
    p01 = bank_q[{y0p, x1p}];
    p10 = bank_q[{y1p, x0p}];
    p11 = bank_q[{y1p, x1p}];
  end

  assign lane_ctl.h_en = adv3;

  // color lanes
  for (genvar c = 0; c < 3; c++) begin : g_lane
    sbr_lane u_lane (
      .clk   (clk),
      .ctl   (lane_ctl),
      .top_a (p00[c*CH_W +: CH_W]),
      .top_b (p01[c*CH_W +: CH_W]),
      .bot_a (p10[c*CH_W +: CH_W]),
      .bot_b (p11[c*CH_W +: CH_W]),
      .fx    (fx2),
      .fy    (fy2),
      .pix   (lane_pix[c])
    );
  end

  always_ff @(posedge clk) begin
    if (adv3) oor3 <= oor2;
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (adv4) begin
      red_r   <= oor3 ? '0 : lane_pix[0];
      green_r <= oor3 ? '0 : lane_pix[1];
      blue_r  <= oor3 ? '0 : lane_pix[2];
      oor_r   <= oor3;
    end
  end

  assign rsp.valid        = v4;
  assign rsp.red_out      = red_r;
  assign rsp.green_out    = green_r;
  assign rsp.blue_out     = blue_r;
  assign rsp.out_of_range = oor_r;

  // checks
  a_no_req_while_div: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !col_busy && !row_busy)
    else $error("request taken while steps recompute");

  a_cfg_blocks_req: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !req.ready)
    else $error("request taken right after configuration write");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.out_of_range) |->
      (rsp.red_out == 8'd0 && rsp.green_out == 8'd0 && rsp.blue_out == 8'd0))
    else $error("out of range result with nonzero color");

endmodule

### rtl/sbr_step_div.sv
// ----------------------------------------------------------------------------
// sbr_step_div
// Restoring divider, one quotient bit per cycle, for the scale step.
// ----------------------------------------------------------------------------
module sbr_step_div
  import sbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] dividend,
  input  logic [9:0]        divisor,
  output logic [STEP_W-1:0] quotient,
  output logic              busy
);

  localparam logic [4:0] LAST = 5'(STEP_W - 1);

  logic [4:0]        cnt;
  logic [9:0]        rem;
  logic [STEP_W-1:0] quo;
  logic [10:0]       trial;
  logic [10:0]       diff;
  logic              qbit;
  logic [9:0]        rem_next;

  // trial subtract
  always_comb begin
    trial    = {rem, quo[STEP_W-1]};
    diff     = trial - {1'b0, divisor};
    qbit     = (trial >= {1'b0, divisor});
    rem_next = qbit ? diff[9:0] : trial[9:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == LAST) busy <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[STEP_W-2:0], qbit};
    end
  end

  assign quotient = quo;

endmodule

### rtl/sbr_bank.sv
// ----------------------------------------------------------------------------
// sbr_bank
// One parity bank of the source image, one write and one registered read.
// ----------------------------------------------------------------------------
module sbr_bank
  import sbr_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [BANK_AW-1:0] waddr,
  input  logic [PIX_W-1:0]   wdata,
  input  logic               re,
  input  logic [BANK_AW-1:0] raddr,
  output logic [PIX_W-1:0]   rdata
);

  logic [PIX_W-1:0] mem [BANK_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

### rtl/sbr_lane.sv
// ----------------------------------------------------------------------------
// sbr_lane
// One color channel: horizontal blend of both rows, then vertical blend.
// ----------------------------------------------------------------------------
module sbr_lane
  import sbr_pkg::*;
(
  input  logic                 clk,
  input  lane_ctl_t            ctl,
  input  logic [CH_W-1:0]      top_a,
  input  logic [CH_W-1:0]      top_b,
  input  logic [CH_W-1:0]      bot_a,
  input  logic [CH_W-1:0]      bot_b,
  input  logic [FRAC_BITS-1:0] fx,
  input  logic [FRAC_BITS-1:0] fy,
  output logic [CH_W-1:0]      pix
);

  localparam int SUM_W = CH_W + FRAC_BITS + 1;

  logic [FRAC_BITS:0]     wx0, wy0;
  logic [SUM_W-1:0]       sum_top, sum_bot, sum_v;
  logic [CH_W-1:0]        top_r, bot_r;
  logic [FRAC_BITS-1:0]   fy_r;

  // horizontal blend of both rows
  always_comb begin
    wx0     = (FRAC_BITS+1)'(1) << FRAC_BITS;
    wx0     = wx0 - {1'b0, fx};
    sum_top = SUM_W'(top_a) * SUM_W'(wx0) + SUM_W'(top_b) * SUM_W'(fx);
    sum_bot = SUM_W'(bot_a) * SUM_W'(wx0) + SUM_W'(bot_b) * SUM_W'(fx);
  end

  always_ff @(posedge clk) begin
    if (ctl.h_en) begin
      top_r <= sum_top[FRAC_BITS +: CH_W];
      bot_r <= sum_bot[FRAC_BITS +: CH_W];
      fy_r  <= fy;
    end
  end

  // vertical blend
  always_comb begin
    wy0   = (FRAC_BITS+1)'(1) << FRAC_BITS;
    wy0   = wy0 - {1'b0, fy_r};
    sum_v = SUM_W'(top_r) * SUM_W'(wy0) + SUM_W'(bot_r) * SUM_W'(fy_r);
    pix   = sum_v[FRAC_BITS +: CH_W];
  end

endmodule
